// ===== sv/slcd_pkg.sv =====
// shared types, constants and segment tables for the segment display writer
package slcd_pkg;

    localparam logic [2:0] OP_DIGIT   = 3'd0;
    localparam logic [2:0] OP_LETTER  = 3'd1;
    localparam logic [2:0] OP_SYMBOL  = 3'd2;
    localparam logic [2:0] OP_REDRAW  = 3'd3;
    localparam logic [2:0] OP_COMMAND = 3'd4;
    localparam logic [2:0] OP_FILL    = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;

    localparam logic [7:0] SYM_LOW     = 8'h08;
    localparam logic [7:0] SYM_HIGH    = 8'h80;
    localparam logic [7:0] BLANK_CODE  = 8'hFF;
    localparam logic [7:0] FILL_BEYOND = 8'hFF;
    localparam logic [7:0] DIGIT_MAX   = 8'd9;

    localparam logic [2:0] HEAD_PREFIX = 3'b101;
    localparam logic [3:0] CMD_PREFIX  = 4'b1000;
    localparam logic [3:0] HEAD_LENGTH = 4'd9;
    localparam logic [3:0] CMD_LENGTH  = 4'd12;

    localparam int GLYPH_TABLE_SIZE = 19;
    localparam int FILL_TABLE_SIZE  = 8;

    localparam logic [7:0] DIGITS_HIGH [10] = '{
        8'h5F, 8'h06, 8'h6B, 8'h2F, 8'h36, 8'h3D, 8'h7D, 8'h07, 8'h7F, 8'h3F
    };
    localparam logic [7:0] DIGITS_LOW [10] = '{
        8'hF5, 8'h60, 8'hD3, 8'hF2, 8'h66, 8'hB6, 8'hB7, 8'hE0, 8'hF7, 8'hF6
    };
    localparam logic [7:0] FILL_PATTERN [FILL_TABLE_SIZE] = '{
        8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF
    };

    localparam logic [7:0] GLYPH_ASCII [GLYPH_TABLE_SIZE] = '{
        8'h41, 8'h43, 8'h45, 8'h46, 8'h48, 8'h4C, 8'h4F, 8'h50, 8'h53, 8'h55,
        8'h62, 8'h63, 8'h64, 8'h68, 8'h69, 8'h6E, 8'h6F, 8'h72, 8'h75
    };
    localparam logic [7:0] GLYPH_HIGH [GLYPH_TABLE_SIZE] = '{
        8'h77, 8'h59, 8'h79, 8'h71, 8'h76, 8'h58, 8'h5F, 8'h73, 8'h3D, 8'h5E,
        8'h7C, 8'h68, 8'h6E, 8'h74, 8'h40, 8'h64, 8'h6C, 8'h60, 8'h4C
    };
    localparam logic [7:0] GLYPH_LOW [GLYPH_TABLE_SIZE] = '{
        8'hE7, 8'h95, 8'h97, 8'h87, 8'h67, 8'h15, 8'hF5, 8'hE3, 8'hB6, 8'h75,
        8'h37, 8'h13, 8'h73, 8'h27, 8'h01, 8'h23, 8'h33, 8'h03, 8'h31
    };

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] position;
        logic [7:0] value;
    } req_t;

    typedef struct packed {
        logic [11:0] chunk_bits;
        logic [3:0]  chunk_length;
        logic        lsb_first;
        logic        frame_end;
    } res_t;

    typedef struct packed {
        logic load;
        logic rd_pos;
        logic wr_mod;
        logic fill_wr;
        logic clear_all;
        logic rd_idx;
        logic cnt_clr;
        logic emit_header;
        logic emit_data;
        logic emit_cmd;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic cnt_at_end;
    } dp_status_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } glyph_hit_t;

    function automatic logic [7:0] digit_code(input logic [7:0] v, input logic low_side);
        logic [7:0] code;
        code = 8'h00;
        if (v <= DIGIT_MAX)
        begin
            code = low_side ? DIGITS_LOW[v[3:0]] : DIGITS_HIGH[v[3:0]];
        end
        return code;
    endfunction

    function automatic glyph_hit_t glyph_lookup(input logic [7:0] ch, input logic low_side,
                                                input int count);
        glyph_hit_t r;
        r.hit  = 1'b0;
        r.code = 8'h00;
        for (int i = 0; i < GLYPH_TABLE_SIZE; i++)
        begin
            if (i < count && GLYPH_ASCII[i] == ch)
            begin
                r.hit  = 1'b1;
                r.code = low_side ? GLYPH_LOW[i] : GLYPH_HIGH[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/slcd_ram.sv =====
// generic single write port ram with registered read
module slcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/slcd_ctrl.sv =====
// controller state machine for the segment display writer
module slcd_ctrl import slcd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] opcode,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_FILL,
        S_CLEAR,
        S_HEAD,
        S_DATA,
        S_CMD
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode) inside
                        OP_DIGIT, OP_LETTER, OP_SYMBOL: state_next = S_READ;
                        OP_REDRAW:                      state_next = S_HEAD;
                        OP_COMMAND:                     state_next = S_CMD;
                        OP_FILL:                        state_next = S_FILL;
                        OP_CLEAR:                       state_next = S_CLEAR;
                        default:                        state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:  state_next = S_WRITE;
            S_WRITE: state_next = S_IDLE;
            S_FILL:  state_next = status.fill_last ? S_HEAD : S_FILL;
            S_CLEAR: state_next = S_HEAD;
            S_HEAD:  state_next = S_DATA;
            S_DATA:  state_next = status.cnt_at_end ? S_IDLE : S_DATA;
            S_CMD:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.load        = (state_reg == S_IDLE) && start;
        cmd.rd_pos      = (state_reg == S_READ);
        cmd.wr_mod      = (state_reg == S_WRITE);
        cmd.fill_wr     = (state_reg == S_FILL);
        cmd.cnt_clr     = (state_reg == S_FILL) && status.fill_last;
        cmd.clear_all   = (state_reg == S_CLEAR);
        cmd.emit_header = (state_reg == S_HEAD);
        cmd.rd_idx      = (state_reg == S_HEAD) || (state_reg == S_DATA);
        cmd.emit_data   = (state_reg == S_DATA);
        cmd.emit_cmd    = (state_reg == S_CMD);
    end

    assign busy = busy_reg;

`ifndef NO_ASSERTIONS
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_mod, cmd.fill_wr, cmd.emit_header, cmd.emit_data, cmd.emit_cmd,
                  cmd.clear_all}))
        else $error("more than one datapath action in a cycle");

    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_data && status.cnt_at_end |=> !busy && !cmd.emit_data)
        else $error("redraw did not stop after the last byte");

    a_fill_to_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_wr && status.fill_last |=> cmd.emit_header)
        else $error("fill sweep did not hand over to redraw");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load)
        else $error("request taken while busy");
`endif

endmodule

// ===== sv/slcd_dp.sv =====
// datapath: display buffer, byte update logic, chunk builder and result register
module slcd_dp import slcd_pkg::*; #(
    parameter int DISPLAY_BYTES  = 8,
    parameter int BITS_PER_ENTRY = 8,
    parameter int LETTER_COUNT   = 19
) (
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       request,
    input  logic [5:0] start_address,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       strobe,
    output res_t       result
);

    localparam int AW = DISPLAY_BYTES > 1 ? $clog2(DISPLAY_BYTES) : 1;
    localparam int CW = $clog2(DISPLAY_BYTES + 1);
    localparam logic [7:0] ENTRY_MASK = 8'((1 << BITS_PER_ENTRY) - 1);

    req_t                     req_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [DISPLAY_BYTES-1:0] valid_reg, valid_next;
    logic                     valid_rd_reg;
    logic                     strobe_reg, strobe_next;
    res_t                     result_reg, result_next;

    logic [31:0]   pos_wide, cnt_wide;
    logic [AW-1:0] pos_addr, cnt_addr;
    logic          pos_in_range, cnt_in_range, low_side;
    logic [7:0]    sym_bit, old_byte, mod_byte, fill_byte, ram_rd;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data;
    glyph_hit_t    glyph;

    assign pos_wide     = 32'(req_reg.position);
    assign cnt_wide     = 32'(cnt_reg);
    assign pos_addr     = pos_wide[AW-1:0];
    assign cnt_addr     = cnt_wide[AW-1:0];
    assign pos_in_range = pos_wide < DISPLAY_BYTES;
    assign cnt_in_range = cnt_wide < DISPLAY_BYTES;
    assign low_side     = req_reg.position < 3'd4;
    assign sym_bit      = low_side ? SYM_LOW : SYM_HIGH;
    assign old_byte     = valid_rd_reg ? ram_rd : 8'h00;
    assign glyph        = glyph_lookup(req_reg.value, low_side, LETTER_COUNT);
    assign fill_byte    = (cnt_wide < FILL_TABLE_SIZE) ? FILL_PATTERN[cnt_wide[2:0]]
                                                       : FILL_BEYOND;

    always_comb
    begin
        case (req_reg.opcode)
            OP_DIGIT:
                mod_byte = digit_code(req_reg.value, low_side) | (old_byte & sym_bit);
            OP_LETTER:
            begin
                if (req_reg.value == BLANK_CODE)
                    mod_byte = old_byte & sym_bit;
                else if (glyph.hit)
                    mod_byte = glyph.code | (old_byte & sym_bit);
                else
                    mod_byte = old_byte;
            end
            OP_SYMBOL:
                mod_byte = (req_reg.value != 8'h00) ? (old_byte | sym_bit)
                                                    : (old_byte & ~sym_bit);
            default:
                mod_byte = old_byte;
        endcase
    end

    assign wr_en   = (cmd.wr_mod && pos_in_range) || cmd.fill_wr;
    assign wr_addr = cmd.fill_wr ? cnt_addr : pos_addr;
    assign wr_data = cmd.fill_wr ? fill_byte : mod_byte;
    assign rd_en   = cmd.rd_pos || (cmd.rd_idx && cnt_in_range);
    assign rd_addr = cmd.rd_pos ? pos_addr : cnt_addr;

    slcd_ram #(
        .WIDTH(8),
        .DEPTH(DISPLAY_BYTES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(ram_rd)
    );

    assign status.fill_last  = cnt_reg == CW'(DISPLAY_BYTES - 1);
    assign status.cnt_at_end = cnt_reg == CW'(DISPLAY_BYTES);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load || cmd.cnt_clr)
            cnt_next = '0;
        else if (cmd.fill_wr || cmd.rd_idx)
            cnt_next = cnt_reg + 1'b1;

        valid_next = valid_reg;
        if (cmd.clear_all)
            valid_next = '0;
        else if (wr_en)
            valid_next[wr_addr] = 1'b1;
    end

    always_comb
    begin
        strobe_next = cmd.emit_header || cmd.emit_data || cmd.emit_cmd;
        result_next = result_reg;
        if (cmd.emit_header)
        begin
            result_next.chunk_bits   = {3'b000, HEAD_PREFIX, start_address};
            result_next.chunk_length = HEAD_LENGTH;
            result_next.lsb_first    = 1'b0;
            result_next.frame_end    = 1'b0;
        end
        else if (cmd.emit_data)
        begin
            result_next.chunk_bits   = {4'h0, old_byte & ENTRY_MASK};
            result_next.chunk_length = 4'(BITS_PER_ENTRY);
            result_next.lsb_first    = 1'b1;
            result_next.frame_end    = status.cnt_at_end;
        end
        else if (cmd.emit_cmd)
        begin
            result_next.chunk_bits   = {CMD_PREFIX, req_reg.value};
            result_next.chunk_length = CMD_LENGTH;
            result_next.lsb_first    = 1'b0;
            result_next.frame_end    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
            if (rd_en)
                valid_rd_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= request;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== sv/segment_lcd_buffer_and_serial_writer.sv =====
// top level: apb register, controller and datapath of the segment display writer
//
// channel   direction  handshake               payload
// request   in         start && !busy          request (opcode, position, value)
// result    out        strobe, one cycle       result (chunk_bits, chunk_length,
//                                              lsb_first, frame_end)
// config    in         psel penable pwrite     paddr, pwdata, prdata
//
// digit, letter and symbol requests do a buffer read, then a write back
// redraw emits a header chunk, then one data chunk a cycle from the ram read port
// clear resets the buffer before redraw, fill all does ram writes to every byte before redraw
// a command emits a single chunk; results appear in the cycle after the datapath builds them
// reset clears the buffer to zero and start_address to 0; results cannot be stalled
module segment_lcd_buffer_and_serial_writer import slcd_pkg::*; #(
    parameter int DISPLAY_BYTES  = 8,
    parameter int BITS_PER_ENTRY = 8,
    parameter int LETTER_COUNT   = 19
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        strobe,
    output res_t        result
);

    logic [5:0] start_address_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_address_reg <= 6'd0;
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
            start_address_reg <= pwdata[5:0];
        else if (psel && penable && pwrite)
            start_address_reg <= pwdata[5:0];
    end

    assign pready = 1'b1;
    assign prdata = {26'd0, start_address_reg};

    slcd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .opcode(request.opcode),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    slcd_dp #(
        .DISPLAY_BYTES (DISPLAY_BYTES),
        .BITS_PER_ENTRY(BITS_PER_ENTRY),
        .LETTER_COUNT  (LETTER_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .start_address(start_address_reg),
        .cmd          (cmd),
        .status       (status),
        .strobe       (strobe),
        .result       (result)
    );

endmodule
